// ===== hw/rtl/bba_pkg.sv =====
// Package with the shared constants, types and helper functions of the block bitmap allocator.
`default_nettype none
package bba_pkg;

	localparam int NUM_BLOCKS = 4096;
	localparam int WORD_BITS  = 64;
	localparam int MARK_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int WADDR_W    = $clog2(MARK_WORDS);
	localparam int EW_W       = CNT_W - BIT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FREE
	} bba_state_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} bba_op_t;

	typedef struct packed {
		logic                 rd_en;
		logic [WADDR_W-1:0]   rd_addr;
		logic                 wr_en;
		logic [WADDR_W-1:0]   wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} mark_ram_req_t;

	function automatic logic [WORD_BITS-1:0] lowest_onehot(input logic [WORD_BITS-1:0] v);
		return v & (~v + {{(WORD_BITS-1){1'b0}}, 1'b1});
	endfunction

	function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_BITS-1:0] oh);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (oh[i]) begin
				idx = idx | BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bba_mark_ram.sv =====
// Used-mark memory with a registered read port and per-word valid bits cleared at reset.
`default_nettype none
module bba_mark_ram (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bba_pkg::mark_ram_req_t        req,
	output logic [bba_pkg::WORD_BITS-1:0]      rd_data
);

	logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::MARK_WORDS];
	logic [bba_pkg::MARK_WORDS-1:0] vld_q;
	logic [bba_pkg::WORD_BITS-1:0] data_s1;
	logic                          vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_s1 <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_s1 <= vld_q[req.rd_addr];
			end
		end
	end

	// A word never written since reset reads as all free.
	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/block_bitmap_allocator.sv =====
// Top level of the first-fit block bitmap allocator.
// Usage: raise start with operation and block_index while busy is low; the
// transaction is accepted at that clock edge and busy rises for the work.
// An allocate reads one bitmap word per cycle from word 0 upward and stops at
// the first word with a free block below the configured limit; the scan is
// paced by the single read port of the mark memory. When the limit is zero an
// allocate reads nothing, busy stays low and the result shows in the cycle
// after start. A free reads one word and, if the block is in use, writes it
// back with its bit cleared. The result shows on granted_index, success and
// free_count for exactly one cycle with done high, in the cycle in which busy
// has already fallen, so a new transaction may start in that cycle.
// The receiver cannot stall; results must be taken when done is high.
// The limit is written through cfg_wr_en and cfg_wr_data; the user must do so
// only while busy is low, as the block itself does not enforce it.
// Reset clears every used mark, the count of blocks in use and sets the
// limit to 4096; per-word valid bits make the mark memory read as free at
// once, so no clearing pass is needed.
`default_nettype none
module block_bitmap_allocator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         operation,
	input  wire logic [bba_pkg::IDX_W-1:0]    block_index,
	input  wire logic                         cfg_wr_en,
	input  wire logic [bba_pkg::CNT_W-1:0]    cfg_wr_data,
	output logic                              done,
	output logic [bba_pkg::IDX_W-1:0]         granted_index,
	output logic                              success,
	output logic [bba_pkg::CNT_W-1:0]         free_count
);

	bba_pkg::bba_state_t state_q, state_d;
	bba_pkg::mark_ram_req_t ram_req;

	logic [bba_pkg::CNT_W-1:0]     limit_q;
	logic [bba_pkg::CNT_W-1:0]     used_q;
	logic [bba_pkg::CNT_W-1:0]     used_d;
	logic [bba_pkg::IDX_W-1:0]     blk_q;
	logic [bba_pkg::WADDR_W-1:0]   scan_addr_q;
	logic [bba_pkg::WADDR_W-1:0]   addr_s1;
	logic [bba_pkg::WORD_BITS-1:0] rd_data;

	logic [bba_pkg::CNT_W-1:0]     scan_end;
	logic [bba_pkg::CNT_W-1:0]     scan_end_m1;
	logic [bba_pkg::WADDR_W-1:0]   last_word;
	logic [bba_pkg::EW_W-1:0]      end_word;
	logic [bba_pkg::WORD_BITS-1:0] range_mask;
	logic [bba_pkg::WORD_BITS-1:0] cand;
	logic [bba_pkg::WORD_BITS-1:0] cand_oh;
	logic [bba_pkg::BIT_W-1:0]     cand_bit;
	logic [bba_pkg::WORD_BITS-1:0] free_bit;
	logic                          accept;
	logic                          finish;
	logic                          ok;
	logic [bba_pkg::IDX_W-1:0]     granted_d;
	logic [bba_pkg::CNT_W-1:0]     free_d;

	bba_mark_ram u_mark_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	assign accept = start && (state_q == bba_pkg::ST_IDLE);
	assign busy   = (state_q != bba_pkg::ST_IDLE);

	assign scan_end    = (limit_q > bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS)) ?
	                     bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS) : limit_q;
	assign scan_end_m1 = scan_end - {{(bba_pkg::CNT_W-1){1'b0}}, 1'b1};
	assign last_word   = scan_end_m1[bba_pkg::BIT_W +: bba_pkg::WADDR_W];
	assign end_word    = scan_end[bba_pkg::CNT_W-1:bba_pkg::BIT_W];

	always_comb begin
		if (bba_pkg::EW_W'(addr_s1) < end_word) begin
			range_mask = '1;
		end else begin
			range_mask = ~({bba_pkg::WORD_BITS{1'b1}} << scan_end[bba_pkg::BIT_W-1:0]);
		end
	end

	assign cand     = ~rd_data & range_mask;
	assign cand_oh  = bba_pkg::lowest_onehot(cand);
	assign cand_bit = bba_pkg::onehot_index(cand_oh);
	assign free_bit = {{(bba_pkg::WORD_BITS-1){1'b0}}, 1'b1} << blk_q[bba_pkg::BIT_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				if (start) begin
					if (operation == bba_pkg::OP_FREE) begin
						state_d = bba_pkg::ST_FREE;
					end else if (scan_end != '0) begin
						state_d = bba_pkg::ST_SCAN;
					end
				end
			end
			bba_pkg::ST_SCAN: begin
				if (finish) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			bba_pkg::ST_FREE: begin
				state_d = bba_pkg::ST_IDLE;
			end
			default: begin
				state_d = bba_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_req         = '0;
		ram_req.rd_addr = scan_addr_q;
		ram_req.wr_addr = addr_s1;
		finish          = 1'b0;
		ok              = 1'b0;
		granted_d       = '0;
		used_d          = used_q;
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				if (start) begin
					if (operation == bba_pkg::OP_FREE) begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = block_index[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
					end else if (scan_end != '0) begin
						ram_req.rd_en   = 1'b1;
						ram_req.rd_addr = '0;
					end else begin
						finish = 1'b1;
					end
				end
			end
			bba_pkg::ST_SCAN: begin
				if (cand != '0) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_data = rd_data | cand_oh;
					finish          = 1'b1;
					ok              = 1'b1;
					granted_d       = {addr_s1, cand_bit};
					used_d          = used_q + {{(bba_pkg::CNT_W-1){1'b0}}, 1'b1};
				end else if (addr_s1 == last_word) begin
					finish = 1'b1;
				end else begin
					ram_req.rd_en = 1'b1;
				end
			end
			bba_pkg::ST_FREE: begin
				finish = 1'b1;
				if ((rd_data & free_bit) != '0) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_data = rd_data & ~free_bit;
					ok              = 1'b1;
					granted_d       = blk_q;
					if (used_q != '0) begin
						used_d = used_q - {{(bba_pkg::CNT_W-1){1'b0}}, 1'b1};
					end
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	assign free_d = (used_d >= limit_q) ? '0 : (limit_q - used_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bba_pkg::ST_IDLE;
			limit_q     <= bba_pkg::CNT_W'(4096);
			used_q      <= '0;
			scan_addr_q <= '0;
			done        <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			done    <= finish;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				scan_addr_q <= {{(bba_pkg::WADDR_W-1){1'b0}}, 1'b1};
			end else if (ram_req.rd_en) begin
				scan_addr_q <= scan_addr_q + {{(bba_pkg::WADDR_W-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= block_index;
		end
		if (ram_req.rd_en) begin
			addr_s1 <= ram_req.rd_addr;
		end
		if (finish) begin
			granted_index <= granted_d;
			success       <= ok;
			free_count    <= free_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bba_checker.sv =====
// Port-level checker for the block bitmap allocator and its bind statement.
`default_nettype none
module bba_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic                      done,
	input wire logic [bba_pkg::IDX_W-1:0] granted_index,
	input wire logic                      success,
	input wire logic [bba_pkg::CNT_W-1:0] free_count
);

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result shown while a transaction is still in progress.");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("Accepted transaction neither started work nor finished.");

	a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("Busy dropped without a result.");

	a_fail_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !success) |-> (granted_index == '0))
		else $error("Failed transaction reported a nonzero index.");

	a_free_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (free_count <= bba_pkg::CNT_W'(8191)))
		else $error("Free count out of range.");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.granted_index (granted_index),
	.success       (success),
	.free_count    (free_count)
);
`default_nettype wire

// ===== dv/block_bitmap_allocator_tb.sv =====
// Self-checking testbench for the first-fit block bitmap allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module block_bitmap_allocator_tb;

	typedef struct packed {
		logic [bba_pkg::IDX_W-1:0] idx;
		logic                      ok;
		logic [bba_pkg::CNT_W-1:0] fc;
	} grant_t;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		bba_pkg::bba_op_t          op;
		logic [bba_pkg::IDX_W-1:0] idx;
		logic [bba_pkg::CNT_W-1:0] cfg_value;
		bit                        typed;
		grant_t                    known;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      operation;
	logic [bba_pkg::IDX_W-1:0] block_index;
	logic                      cfg_wr_en;
	logic [bba_pkg::CNT_W-1:0] cfg_wr_data;
	logic                      done;
	logic [bba_pkg::IDX_W-1:0] granted_index;
	logic                      success;
	logic [bba_pkg::CNT_W-1:0] free_count;

	logic                      block_used [bba_pkg::NUM_BLOCKS];
	int                        blocks_taken;
	logic [bba_pkg::CNT_W-1:0] block_limit;
	grant_t                    pending_grants [$];
	int                        errors;
	int                        results_seen;
	int                        grants_ok;
	int                        grants_refused;
	int                        limits_written;
	bit                        gapless;
	dir_row_t                  directed_rows [25];

	block_bitmap_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.block_index  (block_index),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.done         (done),
		.granted_index(granted_index),
		.success      (success),
		.free_count   (free_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout at %0t with %0d transactions outstanding", $time, pending_grants.size());
		$display("block_bitmap_allocator_tb: done, errors");
		$finish;
	end

	function automatic logic [bba_pkg::CNT_W-1:0] blocks_free_now();
		if (blocks_taken >= int'(block_limit)) begin
			return '0;
		end
		return bba_pkg::CNT_W'(int'(block_limit) - blocks_taken);
	endfunction

	function automatic grant_t predict_grant(bba_pkg::bba_op_t op,
		logic [bba_pkg::IDX_W-1:0] idx);
		grant_t g;
		int     scan_end;
		g = '0;
		if (op == bba_pkg::OP_ALLOC) begin
			scan_end = (int'(block_limit) > bba_pkg::NUM_BLOCKS) ?
				bba_pkg::NUM_BLOCKS : int'(block_limit);
			for (int i = 0; i < scan_end; i++) begin
				if (!block_used[i]) begin
					block_used[i] = 1'b1;
					blocks_taken++;
					g.idx = bba_pkg::IDX_W'(i);
					g.ok  = 1'b1;
					break;
				end
			end
		end else if (block_used[idx]) begin
			block_used[idx] = 1'b0;
			if (blocks_taken > 0) begin
				blocks_taken--;
			end
			g.idx = idx;
			g.ok  = 1'b1;
		end
		g.fc = blocks_free_now();
		return g;
	endfunction

	function automatic logic [bba_pkg::IDX_W-1:0] next_used_block(
		logic [bba_pkg::IDX_W-1:0] from);
		logic [bba_pkg::IDX_W-1:0] j;
		for (int k = 0; k < bba_pkg::NUM_BLOCKS; k++) begin
			j = from + bba_pkg::IDX_W'(k);
			if (block_used[j]) begin
				return j;
			end
		end
		return from;
	endfunction

	task automatic issue_request(bba_pkg::bba_op_t op, logic [bba_pkg::IDX_W-1:0] idx,
		bit typed, grant_t known);
		int     gap;
		grant_t g;
		gap = gapless ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		operation   <= op;
		block_index <= idx;
		do @(posedge clk); while (busy);
		g = predict_grant(op, idx);
		pending_grants.push_back(typed ? known : g);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(logic [bba_pkg::CNT_W-1:0] value);
		drain();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		block_limit = value;
		limits_written++;
	endtask

	task automatic run_phase(logic [bba_pkg::CNT_W-1:0] limit, int count, int alloc_pct);
		bba_pkg::bba_op_t          op;
		logic [bba_pkg::IDX_W-1:0] idx;
		write_limit(limit);
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				gapless = ($urandom_range(0, 3) == 0);
			end
			op  = ($urandom_range(0, 99) < alloc_pct) ? bba_pkg::OP_ALLOC : bba_pkg::OP_FREE;
			idx = bba_pkg::IDX_W'($urandom);
			if (op == bba_pkg::OP_FREE && $urandom_range(0, 99) < 75) begin
				idx = next_used_block(idx);
			end
			issue_request(op, idx, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && done) begin
			results_seen++;
			if (success) begin
				grants_ok++;
			end else begin
				grants_refused++;
			end
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result: index %0d success %0b free %0d",
					$time, granted_index, success, free_count);
				errors++;
			end else begin
				want = pending_grants.pop_front();
				if (granted_index !== want.idx) begin
					$display("%0t: granted_index expected %0d actual %0d",
						$time, want.idx, granted_index);
					errors++;
				end
				if (success !== want.ok) begin
					$display("%0t: success expected %0b actual %0b", $time, want.ok, success);
					errors++;
				end
				if (free_count !== want.fc) begin
					$display("%0t: free_count expected %0d actual %0d",
						$time, want.fc, free_count);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = bba_pkg::OP_ALLOC;
		block_index = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		errors         = 0;
		results_seen   = 0;
		grants_ok      = 0;
		grants_refused = 0;
		limits_written = 0;
		gapless        = 1'b0;
		blocks_taken   = 0;
		block_limit    = bba_pkg::CNT_W'(4096);
		for (int i = 0; i < bba_pkg::NUM_BLOCKS; i++) begin
			block_used[i] = 1'b0;
		end

		directed_rows = '{
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 13'd0, 1'b1, '{12'd0, 1'b1, 13'd4095}},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'hFFF, 13'd0, 1'b1, '{12'd1, 1'b1, 13'd4094}},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'h000, 13'd0, 1'b1, '{12'd0, 1'b1, 13'd4095}},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'h000, 13'd0, 1'b1, '{12'd0, 1'b0, 13'd4095}},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'hFFF, 13'd0, 1'b1, '{12'd0, 1'b0, 13'd4095}},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h555, 13'd0, 1'b1, '{12'd0, 1'b1, 13'd4094}},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'hAAA, 13'd0, 1'b1, '{12'd0, 1'b0, 13'd4094}},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'h555, 13'd0, 1'b1, '{12'd0, 1'b0, 13'd4094}},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'h001, 13'd0, 1'b1, '{12'd1, 1'b1, 13'd4095}},
			'{ROW_CFG, bba_pkg::OP_ALLOC, 12'h000, 13'd0, 1'b0, '0},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 13'd0, 1'b1, '{12'd0, 1'b0, 13'd0}},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'h000, 13'd0, 1'b1, '{12'd0, 1'b1, 13'd0}},
			'{ROW_CFG, bba_pkg::OP_ALLOC, 12'h000, 13'd1, 1'b0, '0},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 13'd0, 1'b1, '{12'd0, 1'b1, 13'd0}},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 13'd0, 1'b1, '{12'd0, 1'b0, 13'd0}},
			'{ROW_CFG, bba_pkg::OP_ALLOC, 12'h000, 13'd8191, 1'b0, '0},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 13'd0, 1'b1, '{12'd1, 1'b1, 13'd8189}},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'h001, 13'd0, 1'b1, '{12'd1, 1'b1, 13'd8190}},
			'{ROW_CFG, bba_pkg::OP_ALLOC, 12'h000, 13'd4096, 1'b0, '0},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 13'd0, 1'b1, '{12'd1, 1'b1, 13'd4094}},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h0F0, 13'd0, 1'b0, '0},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h00F, 13'd0, 1'b0, '0},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'h002, 13'd0, 1'b0, '0},
			'{ROW_REQ, bba_pkg::OP_ALLOC, 12'h000, 13'd0, 1'b0, '0},
			'{ROW_REQ, bba_pkg::OP_FREE,  12'h003, 13'd0, 1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				write_limit(directed_rows[r].cfg_value);
			end else begin
				issue_request(directed_rows[r].op, directed_rows[r].idx,
					directed_rows[r].typed, directed_rows[r].known);
			end
		end

		run_phase(13'd100, 300, 60);
		run_phase(13'd64, 200, 70);
		run_phase(13'd0, 30, 50);
		run_phase(13'd1, 50, 50);
		run_phase(13'd8191, 200, 75);
		run_phase(13'd20, 150, 40);
		run_phase(13'd4096, 300, 65);
		run_phase(13'd130, 120, 55);

		drain();
		repeat (70) @(posedge clk);

		$display("%0d transactions checked over %0d limit settings (0, 1, 4096 and 8191 among them)",
			results_seen, limits_written);
		$display("%0d succeeded and %0d were refused", grants_ok, grants_refused);
		if (errors == 0) begin
			$display("block_bitmap_allocator_tb: done, clean");
		end else begin
			$display("block_bitmap_allocator_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_mark_ram.sv
hw/rtl/block_bitmap_allocator.sv
hw/rtl/bba_checker.sv
dv/block_bitmap_allocator_tb.sv
